FILE: rtl/ogbp_pkg.sv
// Package for the occupancy grid block pooling core.
// Holds register index codes, field widths and the per-word struct.
// No dependencies.
`timescale 1ns / 1ps

package ogbp_pkg;

    localparam int COST_W     = 8;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BS_REG_W   = 7;
    localparam int DIM_REG_W  = 13;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_BLOCK  = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BLOCK_SIZE     = 2'd0;
    localparam t_cfg_idx CFG_MAP_WIDTH      = 2'd1;
    localparam t_cfg_idx CFG_MAP_HEIGHT     = 2'd2;
    localparam t_cfg_idx CFG_COST_THRESHOLD = 2'd3;

    typedef struct packed {
        logic               or_val;
        logic               col_last;
        logic               emit;
        logic               rib_nz;
        logic               row_end;
        logic               map_end;
        logic [COORD_W-1:0] coarse_col;
        logic [COORD_W-1:0] coarse_row;
    } t_item;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: rtl/ogbp_ifs.sv
// Stream and configuration channel interfaces of the pooling core.
// Depends on ogbp_pkg.
`timescale 1ns / 1ps

interface ogbp_cost_if;
    import ogbp_pkg::*;
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] cost;
    modport source (output valid, output cost, input ready);
    modport sink   (input valid, input cost, output ready);
endinterface

interface ogbp_cell_if;
    import ogbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               occupied;
    logic [COORD_W-1:0] coarse_col;
    logic [COORD_W-1:0] coarse_row;
    logic               row_end;
    logic               map_end;
    modport source (output valid, output occupied, output coarse_col, output coarse_row,
                    output row_end, output map_end, input ready);
    modport sink   (input valid, input occupied, input coarse_col, input coarse_row,
                    input row_end, input map_end, output ready);
endinterface

interface ogbp_cfg_if;
    import ogbp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ogbp_cfg.sv
// Configuration registers of the pooling core and their range clamping.
// Depends on ogbp_pkg.
`timescale 1ns / 1ps

module ogbp_cfg
    import ogbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
    localparam int WW = f_max($clog2(MAX_WIDTH) + 1, DIM_REG_W),
    localparam int HW = f_max($clog2(MAX_HEIGHT) + 1, DIM_REG_W),
    localparam int BW = f_max($clog2(MAX_BLOCK + 1), BS_REG_W)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  t_cfg_idx              i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output logic [BW-1:0]         o_bs,
    output logic [WW-1:0]         o_w,
    output logic [HW-1:0]         o_h,
    output logic [COST_W-1:0]     o_thr
);

    logic [BS_REG_W-1:0]  r_block_size;
    logic [DIM_REG_W-1:0] r_map_width;
    logic [DIM_REG_W-1:0] r_map_height;
    logic [COST_W-1:0]    r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BS_REG_W'(1);
            r_map_width  <= DIM_REG_W'(4096);
            r_map_height <= DIM_REG_W'(4096);
            r_thr        <= COST_W'(253);
        end else if (i_wr) begin
            unique case (i_idx)
                CFG_BLOCK_SIZE:     r_block_size <= i_data[BS_REG_W-1:0];
                CFG_MAP_WIDTH:      r_map_width  <= i_data[DIM_REG_W-1:0];
                CFG_MAP_HEIGHT:     r_map_height <= i_data[DIM_REG_W-1:0];
                CFG_COST_THRESHOLD: r_thr        <= i_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_block_size == '0)
            o_bs = BW'(1);
        else if (BW'(r_block_size) > BW'(MAX_BLOCK))
            o_bs = BW'(MAX_BLOCK);
        else
            o_bs = BW'(r_block_size);

        if (r_map_width == '0)
            o_w = WW'(1);
        else if (WW'(r_map_width) > WW'(MAX_WIDTH))
            o_w = WW'(MAX_WIDTH);
        else
            o_w = WW'(r_map_width);

        if (r_map_height == '0)
            o_h = HW'(1);
        else if (HW'(r_map_height) > HW'(MAX_HEIGHT))
            o_h = HW'(MAX_HEIGHT);
        else
            o_h = HW'(r_map_height);

        o_thr = r_thr;
    end

endmodule

FILE: rtl/ogbp_scan.sv
// Raster position counters and per-cell block bookkeeping of the pooling core.
// Depends on ogbp_pkg.
`timescale 1ns / 1ps

module ogbp_scan
    import ogbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
    localparam int WCW = $clog2(MAX_WIDTH),
    localparam int HCW = $clog2(MAX_HEIGHT),
    localparam int BCW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
    localparam int WW  = f_max(WCW + 1, DIM_REG_W),
    localparam int HW  = f_max(HCW + 1, DIM_REG_W),
    localparam int BW  = f_max($clog2(MAX_BLOCK + 1), BS_REG_W)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [COST_W-1:0] i_cost,
    input  logic [BW-1:0]     i_bs,
    input  logic [WW-1:0]     i_w,
    input  logic [HW-1:0]     i_h,
    input  logic [COST_W-1:0] i_thr,
    output t_item             o_item,
    output logic [WCW-1:0]    o_addr
);

    logic [WCW-1:0] r_fine_col, n_fine_col;
    logic [HCW-1:0] r_fine_row, n_fine_row;
    logic [BCW-1:0] r_cib, n_cib;
    logic [BCW-1:0] r_rib, n_rib;
    logic [WCW-1:0] r_block_col, n_block_col;
    logic [HCW-1:0] r_block_row, n_block_row;
    logic           r_running_or, n_running_or;

    logic last_in_row, last_row, cib_wrap, rib_wrap, col_last, row_last, or_val;

    always_comb begin
        last_in_row = (WW'(r_fine_col) + WW'(1)) >= i_w;
        last_row    = (HW'(r_fine_row) + HW'(1)) >= i_h;
        cib_wrap    = (BW'(r_cib) + BW'(1)) >= i_bs;
        rib_wrap    = (BW'(r_rib) + BW'(1)) >= i_bs;
        col_last    = cib_wrap || last_in_row;
        row_last    = rib_wrap || last_row;
        or_val      = r_running_or || (i_cost > i_thr);

        o_item.or_val     = or_val;
        o_item.col_last   = col_last;
        o_item.emit       = col_last && row_last;
        o_item.rib_nz     = (r_rib != '0);
        o_item.row_end    = last_in_row;
        o_item.map_end    = last_in_row && last_row;
        o_item.coarse_col = COORD_W'(r_block_col);
        o_item.coarse_row = COORD_W'(r_block_row);
        o_addr            = r_block_col;

        n_running_or = col_last ? 1'b0 : or_val;
        n_fine_col   = r_fine_col;
        n_fine_row   = r_fine_row;
        n_cib        = r_cib;
        n_rib        = r_rib;
        n_block_col  = r_block_col;
        n_block_row  = r_block_row;

        if (last_in_row) begin
            n_fine_col  = '0;
            n_cib       = '0;
            n_block_col = '0;
            if (last_row) begin
                n_fine_row  = '0;
                n_rib       = '0;
                n_block_row = '0;
            end else begin
                n_fine_row = r_fine_row + HCW'(1);
                if (rib_wrap) begin
                    n_rib       = '0;
                    n_block_row = r_block_row + HCW'(1);
                end else begin
                    n_rib = r_rib + BCW'(1);
                end
            end
        end else begin
            n_fine_col = r_fine_col + WCW'(1);
            if (cib_wrap) begin
                n_cib       = '0;
                n_block_col = r_block_col + WCW'(1);
            end else begin
                n_cib = r_cib + BCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_col   <= '0;
            r_fine_row   <= '0;
            r_cib        <= '0;
            r_rib        <= '0;
            r_block_col  <= '0;
            r_block_row  <= '0;
            r_running_or <= 1'b0;
        end else if (i_accept) begin
            r_fine_col   <= n_fine_col;
            r_fine_row   <= n_fine_row;
            r_cib        <= n_cib;
            r_rib        <= n_rib;
            r_block_col  <= n_block_col;
            r_block_row  <= n_block_row;
            r_running_or <= n_running_or;
        end
    end

endmodule

FILE: rtl/ogbp_merge.sv
// Column flag memory, flag merge stage and result register of the pooling core.
// Depends on ogbp_pkg.
`timescale 1ns / 1ps

module ogbp_merge
    import ogbp_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int WCW = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    input  logic [WCW-1:0]     i_addr,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_occupied,
    output logic [COORD_W-1:0] o_coarse_col,
    output logic [COORD_W-1:0] o_coarse_row,
    output logic               o_row_end,
    output logic               o_map_end
);

    logic           r_flags [MAX_WIDTH];
    logic           r_mem_q;
    logic           r_fwd_hit;
    logic           r_fwd_val;
    logic           r_s1_valid;
    t_item          r_s1_item;
    logic [WCW-1:0] r_s1_addr;
    logic           r_out_valid;
    t_item          r_out_item;
    logic           r_out_occ;

    logic accept, s1_fire, wr_en, flag, merged;

    always_comb begin
        s1_fire = r_s1_valid && (!r_out_valid || i_ready);
        o_ready = !r_s1_valid || s1_fire;
        accept  = i_valid && o_ready;
        flag    = r_fwd_hit ? r_fwd_val : r_mem_q;
        merged  = r_s1_item.or_val || (r_s1_item.rib_nz && flag);
        wr_en   = s1_fire && r_s1_item.col_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_flags[r_s1_addr] <= merged;
        end
        if (accept) begin
            r_mem_q   <= r_flags[i_addr];
            r_fwd_hit <= wr_en && (r_s1_addr == i_addr);
            r_fwd_val <= merged;
            r_s1_item <= i_item;
            r_s1_addr <= i_addr;
        end
        if (s1_fire) begin
            r_out_item <= r_s1_item;
            r_out_occ  <= merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept)
                r_s1_valid <= 1'b1;
            else if (s1_fire)
                r_s1_valid <= 1'b0;
            if (s1_fire)
                r_out_valid <= r_s1_item.emit;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_occupied   = r_out_occ;
    assign o_coarse_col = r_out_item.coarse_col;
    assign o_coarse_row = r_out_item.coarse_row;
    assign o_row_end    = r_out_item.row_end;
    assign o_map_end    = r_out_item.map_end;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word did not reach the merge stage");

    a_fwd_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_hit) |-> r_s1_valid)
        else $error("forwarded flag without a word in the merge stage");

    a_fwd_on_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wr_en && (r_s1_addr == i_addr)) |=> r_fwd_hit)
        else $error("flag write and read collision not forwarded");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_fire))
        else $error("result appeared without a merge stage transfer");
`endif

endmodule

FILE: rtl/occupancy_grid_block_pooling_core.sv
// Top level of the occupancy grid block pooling core.
// Depends on ogbp_pkg, ogbp_ifs, ogbp_cfg, ogbp_scan and ogbp_merge.
//
// Usage: fine map cells enter on i_cost, one cost word per handshake, in raster
// order. Each block of block_size x block_size cells (partial at the right and
// bottom edges) yields one word on o_cell when its bottom-right cell arrives:
// occupied, coarse column and row, and row_end / map_end markers. Cells that
// close no block yield no word. The user must write registers on i_cfg (index,
// data) only while idle (the core does not enforce it); i_cfg is always ready.
// A result word is registered in the merge stage, then in the output register.
// Throughput: one cell per cycle while o_cell is not held; the column flag
// memory is read when a cell is accepted and written when it leaves the merge
// stage, with a forwarding path for back-to-back hits on the same column.
// Reset: counters, running OR and valid bits clear; registers take their reset
// values; the flag memory is not cleared, since every flag is written on the
// first row of a block row before it is read. No clearing pass is needed.
// Stall: when o_cell is held, the output register keeps its word and one more
// cell can still be taken into the merge stage before i_cost drops ready.
`timescale 1ns / 1ps

module occupancy_grid_block_pooling_core
    import ogbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ogbp_cost_if.sink  i_cost,
    ogbp_cell_if.source o_cell,
    ogbp_cfg_if.sink   i_cfg
);

    localparam int WCW = $clog2(MAX_WIDTH);
    localparam int HCW = $clog2(MAX_HEIGHT);
    localparam int WW  = f_max(WCW + 1, DIM_REG_W);
    localparam int HW  = f_max(HCW + 1, DIM_REG_W);
    localparam int BW  = f_max($clog2(MAX_BLOCK + 1), BS_REG_W);

    logic [BW-1:0]     bs;
    logic [WW-1:0]     w;
    logic [HW-1:0]     h;
    logic [COST_W-1:0] thr;
    t_item             item;
    logic [WCW-1:0]    addr;
    logic              ready;
    logic              accept;

    assign i_cfg.ready  = 1'b1;
    assign i_cost.ready = ready;
    assign accept       = i_cost.valid && ready;

    ogbp_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_cfg.valid),
        .i_idx  (i_cfg.index),
        .i_data (i_cfg.data),
        .o_bs   (bs),
        .o_w    (w),
        .o_h    (h),
        .o_thr  (thr)
    );

    ogbp_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_cost  (i_cost.cost),
        .i_bs    (bs),
        .i_w     (w),
        .i_h     (h),
        .i_thr   (thr),
        .o_item  (item),
        .o_addr  (addr)
    );

    ogbp_merge #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cost.valid),
        .o_ready     (ready),
        .i_item      (item),
        .i_addr      (addr),
        .o_valid     (o_cell.valid),
        .i_ready     (o_cell.ready),
        .o_occupied  (o_cell.occupied),
        .o_coarse_col(o_cell.coarse_col),
        .o_coarse_row(o_cell.coarse_row),
        .o_row_end   (o_cell.row_end),
        .o_map_end   (o_cell.map_end)
    );

endmodule

FILE: verif/tb_occupancy_grid_block_pooling_core.sv
`timescale 1ns / 1ps
// Testbench for occupancy_grid_block_pooling_core: streams cost maps under many register
// settings, predicts every pooled coarse cell and checks each output word field by field.
// Depends on ogbp_pkg, the channel interfaces in ogbp_ifs and the core RTL.

module tb_occupancy_grid_block_pooling_core;
    import ogbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_CELLS   = 1000;
    localparam int CALM_AFTER     = 800;

    typedef struct packed {
        logic               occupied;
        logic [COORD_W-1:0] coarse_col;
        logic [COORD_W-1:0] coarse_row;
        logic               row_end;
        logic               map_end;
    } t_cell;

    logic i_clk;
    logic i_rst_n;

    ogbp_cost_if cost_if ();
    ogbp_cell_if cell_if ();
    ogbp_cfg_if  cfg_if ();

    occupancy_grid_block_pooling_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cost  (cost_if),
        .o_cell  (cell_if),
        .i_cfg   (cfg_if)
    );

    logic [BS_REG_W-1:0]  block_size_q;
    logic [DIM_REG_W-1:0] map_width_q;
    logic [DIM_REG_W-1:0] map_height_q;
    logic [COST_W-1:0]    threshold_q;

    int fine_col;
    int fine_row;
    int col_in_block;
    int row_in_block;
    int block_col;
    int block_row;
    bit run_or;
    bit column_flags [DEF_MAX_WIDTH];

    t_cell pending_cells [$];
    int    errors       = 0;
    int    random_cells = 0;
    bit    calm         = 1'b0;
    int    stall_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic reset_pooling_model();
        block_size_q = 7'd1;
        map_width_q  = 13'd4096;
        map_height_q = 13'd4096;
        threshold_q  = 8'd253;
        fine_col     = 0;
        fine_row     = 0;
        col_in_block = 0;
        row_in_block = 0;
        block_col    = 0;
        block_row    = 0;
        run_or       = 1'b0;
        foreach (column_flags[i]) column_flags[i] = 1'b0;
    endtask

    task automatic pool_cell(input logic [COST_W-1:0] c);
        int    bs;
        int    w;
        int    h;
        int    idx;
        bit    last_in_row;
        bit    last_row;
        bit    col_last;
        bit    row_last;
        bit    v;
        t_cell pooled;
        bs = clamp_dim(block_size_q, DEF_MAX_BLOCK);
        w  = clamp_dim(map_width_q, DEF_MAX_WIDTH);
        h  = clamp_dim(map_height_q, DEF_MAX_HEIGHT);
        last_in_row = (fine_col + 1 >= w);
        last_row    = (fine_row + 1 >= h);
        col_last    = (col_in_block + 1 >= bs) || last_in_row;
        row_last    = (row_in_block + 1 >= bs) || last_row;
        if (c > threshold_q) run_or = 1'b1;
        if (col_last) begin
            idx = (block_col < DEF_MAX_WIDTH) ? block_col : DEF_MAX_WIDTH - 1;
            v   = run_or;
            if (row_in_block != 0) v = v | column_flags[idx];
            column_flags[idx] = v;
            run_or = 1'b0;
            if (row_last) begin
                pooled.occupied   = v;
                pooled.coarse_col = block_col[COORD_W-1:0];
                pooled.coarse_row = block_row[COORD_W-1:0];
                pooled.row_end    = last_in_row;
                pooled.map_end    = last_in_row && last_row;
                pending_cells     = {pending_cells, pooled};
            end
        end
        if (last_in_row) begin
            fine_col     = 0;
            col_in_block = 0;
            block_col    = 0;
            if (last_row) begin
                fine_row     = 0;
                row_in_block = 0;
                block_row    = 0;
            end else begin
                fine_row++;
                if (row_in_block + 1 >= bs) begin
                    row_in_block = 0;
                    block_row++;
                end else begin
                    row_in_block++;
                end
            end
        end else begin
            fine_col++;
            if (col_in_block + 1 >= bs) begin
                col_in_block = 0;
                block_col++;
            end else begin
                col_in_block++;
            end
        end
    endtask

    task automatic check_cell();
        t_cell want;
        if (pending_cells.size() == 0) begin
            report($sformatf("unexpected word col %0d row %0d", cell_if.coarse_col,
                             cell_if.coarse_row));
            return;
        end
        want = pending_cells.pop_front();
        if (cell_if.occupied !== want.occupied)
            report($sformatf("occupied got %0d want %0d (col %0d row %0d)", cell_if.occupied,
                             want.occupied, want.coarse_col, want.coarse_row));
        if (cell_if.coarse_col !== want.coarse_col)
            report($sformatf("coarse_col got %0d want %0d", cell_if.coarse_col,
                             want.coarse_col));
        if (cell_if.coarse_row !== want.coarse_row)
            report($sformatf("coarse_row got %0d want %0d", cell_if.coarse_row,
                             want.coarse_row));
        if (cell_if.row_end !== want.row_end)
            report($sformatf("row_end got %0d want %0d (col %0d row %0d)", cell_if.row_end,
                             want.row_end, want.coarse_col, want.coarse_row));
        if (cell_if.map_end !== want.map_end)
            report($sformatf("map_end got %0d want %0d (col %0d row %0d)", cell_if.map_end,
                             want.map_end, want.coarse_col, want.coarse_row));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && cell_if.valid && cell_if.ready) check_cell();
        if (stall_left > 0) begin
            cell_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            cell_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            cell_if.ready <= 1'b1;
        end
    end

    task automatic send_cost(input logic [COST_W-1:0] c);
        if (!calm && $urandom_range(0, 5) == 0) begin
            cost_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cost_if.valid <= 1'b1;
        cost_if.cost  <= c;
        do @(posedge i_clk); while (!cost_if.ready);
        pool_cell(c);
    endtask

    task automatic drain();
        cost_if.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_BLOCK_SIZE:     block_size_q = value[BS_REG_W-1:0];
            CFG_MAP_WIDTH:      map_width_q  = value[DIM_REG_W-1:0];
            CFG_MAP_HEIGHT:     map_height_q = value[DIM_REG_W-1:0];
            CFG_COST_THRESHOLD: threshold_q  = value[COST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pooling(input int bs, input int w, input int h, input int thr);
        write_reg(CFG_BLOCK_SIZE, bs);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_COST_THRESHOLD, thr);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [COST_W-1:0] pick_cost(input int busy_pct);
        int thr;
        thr = threshold_q;
        if ($urandom_range(0, 9) == 0) return COST_W'($urandom_range(0, 255));
        if (thr < 255 && $urandom_range(1, 100) <= busy_pct)
            return COST_W'($urandom_range(thr + 1, 255));
        return COST_W'($urandom_range(0, thr));
    endfunction

    task automatic send_map(input int busy_pct);
        int cells;
        cells = clamp_dim(map_width_q, DEF_MAX_WIDTH) * clamp_dim(map_height_q, DEF_MAX_HEIGHT);
        repeat (cells) send_cost(pick_cost(busy_pct));
    endtask

    task automatic test_reset_values();
        logic [COST_W-1:0] costs [6] = '{8'd0, 8'd255, 8'd253, 8'd254, 8'd100, 8'd1};
        foreach (costs[i]) send_cost(costs[i]);
        drain();
        // shrink the width under the current position: the row closes on the next word
        set_pooling(1, 7, 4096, 253);
        send_cost(8'd254);
        drain();
        // second row is now the last one: the map closes
        set_pooling(1, 1, 2, 253);
        send_cost(8'd0);
        drain();
    endtask

    task automatic test_threshold_edges();
        logic [COST_W-1:0] costs [9] = '{8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
        set_pooling(2, 3, 3, 0);
        foreach (costs[i]) send_cost(costs[i]);
        drain();
        set_pooling(3, 3, 1, 255);
        repeat (3) send_cost(8'd255);
        drain();
    endtask

    task automatic test_register_clamps();
        logic [COST_W-1:0] costs [6] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254};
        set_pooling(0, 0, 0, 253);
        send_cost(8'd254);
        drain();
        set_pooling(127, 3, 2, 253);
        foreach (costs[i]) send_cost(costs[i]);
        drain();
    endtask

    task automatic test_map_extremes();
        int thr;
        thr = $urandom_range(0, 255);
        // oversized width: run a long row, then shorten it under the position to close the map
        set_pooling(1, 8191, 1, thr);
        repeat (200) send_cost(pick_cost(20));
        drain();
        set_pooling(1, 201, 1, thr);
        send_cost(pick_cost(20));
        drain();
        // tallest block on a one column map, closed early by a shorter height
        set_pooling(DEF_MAX_BLOCK, 1, 4096, thr);
        repeat (150) send_cost(pick_cost(2));
        drain();
        set_pooling(DEF_MAX_BLOCK, 1, 151, thr);
        send_cost(pick_cost(2));
        drain();
    endtask

    task automatic test_random_maps();
        int bs;
        int w;
        int h;
        int thr;
        int busy;
        while (random_cells < RANDOM_CELLS) begin
            case ($urandom_range(0, 9))
                0:       bs = $urandom_range(DEF_MAX_BLOCK + 1, 127);
                1:       bs = 0;
                2:       bs = DEF_MAX_BLOCK;
                default: bs = $urandom_range(1, 8);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(40, 160);
                h = $urandom_range(0, 3);
            end else begin
                w = $urandom_range(0, 24);
                h = $urandom_range(0, 12);
            end
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            set_pooling(bs, w, h, thr);
            busy = $urandom_range(0, 40);
            repeat ($urandom_range(1, 3)) begin
                send_map(busy);
                random_cells += clamp_dim(w, DEF_MAX_WIDTH) * clamp_dim(h, DEF_MAX_HEIGHT);
            end
            if (random_cells >= CALM_AFTER) calm = 1'b1;
            drain();
        end
    endtask

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cost_if.valid && cost_if.ready) || (cell_if.valid && cell_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        cost_if.valid = 1'b0;
        cost_if.cost  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_BLOCK_SIZE;
        cfg_if.data   = '0;
        cell_if.ready = 1'b0;
        reset_pooling_model();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_threshold_edges();
        test_register_clamps();
        test_map_extremes();
        test_random_maps();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ogbp_pkg.sv
rtl/ogbp_ifs.sv
rtl/ogbp_cfg.sv
rtl/ogbp_scan.sv
rtl/ogbp_merge.sv
rtl/occupancy_grid_block_pooling_core.sv
verif/tb_occupancy_grid_block_pooling_core.sv
